@@ rtl/serial_packet_deframer_core_defines.svh @@
// Assertion macros for the deframer RTL.
`ifndef SERIAL_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ rtl/spd_pkg.sv @@
package spd_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Result status codes.
  localparam logic [1:0] ST_KEPT      = 2'd0;
  localparam logic [1:0] ST_LAST      = 2'd1;
  localparam logic [1:0] ST_DISCARDED = 2'd2;
  localparam logic [1:0] ST_ABANDONED = 2'd3;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_PREAMBLE = 3'd0;
  localparam logic [2:0] REG_MAX_LEN  = 3'd1;
  localparam logic [2:0] REG_MIN_LEN  = 3'd2;
  localparam logic [2:0] REG_OWN_ADDR = 3'd3;
  localparam logic [2:0] REG_NET_ID   = 3'd4;

  typedef struct packed {
    logic [7:0] preamble_value;
    logic [7:0] max_frame_length;
    logic [7:0] min_frame_length;
    logic [7:0] own_address;
    logic [7:0] network_id;
  } cfg_t;

endpackage

@@ rtl/spd_if.sv @@
interface spd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] byte_position;
  logic [1:0] status;

  modport source (output valid, output frame_byte, output byte_position, output status,
                  input ready);
  modport sink (input valid, input frame_byte, input byte_position, input status,
                output ready);
endinterface

@@ rtl/spd_cfg_regs.sv @@
module spd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spd_pkg::AddrW-1:0]   paddr,
  input  logic [spd_pkg::DataW-1:0]   pwdata,
  output logic [spd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output spd_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[spd_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_value   <= 8'd255;
      cfg.max_frame_length <= 8'd128;
      cfg.min_frame_length <= 8'd8;
      cfg.own_address      <= 8'd1;
      cfg.network_id       <= 8'd0;
    end else if (wr_en) begin
      case (reg_idx)
        spd_pkg::REG_PREAMBLE: cfg.preamble_value   <= pwdata[7:0];
        spd_pkg::REG_MAX_LEN:  cfg.max_frame_length <= pwdata[7:0];
        spd_pkg::REG_MIN_LEN:  cfg.min_frame_length <= pwdata[7:0];
        spd_pkg::REG_OWN_ADDR: cfg.own_address      <= pwdata[7:0];
        spd_pkg::REG_NET_ID:   cfg.network_id       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spd_pkg::REG_PREAMBLE: prdata = {24'd0, cfg.preamble_value};
      spd_pkg::REG_MAX_LEN:  prdata = {24'd0, cfg.max_frame_length};
      spd_pkg::REG_MIN_LEN:  prdata = {24'd0, cfg.min_frame_length};
      spd_pkg::REG_OWN_ADDR: prdata = {24'd0, cfg.own_address};
      spd_pkg::REG_NET_ID:   prdata = {24'd0, cfg.network_id};
      default:               prdata = '0;
    endcase
  end

endmodule

@@ rtl/spd_parser.sv @@
module spd_parser (
  input  logic          clk,
  input  logic          rst,
  input  spd_pkg::cfg_t cfg,
  spd_rx_if.sink        rx,
  spd_tx_if.source      tx
);

  localparam logic [2:0] PH_PRE0  = 3'd0;
  localparam logic [2:0] PH_PRE1  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_NETID = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Parse state.
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] kept_count;
  logic [7:0] kept_count_next;
  logic [7:0] frame_length;
  logic [7:0] frame_length_next;

  // Result register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic [7:0] out_pos;
  logic [1:0] out_status;

  logic       res_emit;
  logic [7:0] res_pos;
  logic [1:0] res_status;
  logic       out_free;
  logic       advance;
  logic       data_kept;
  logic [7:0] data_count;

  assign out_free = !out_valid || tx.ready;
  assign advance  = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  assign data_kept  = kept_count < frame_length;
  assign data_count = data_kept ? kept_count + 8'd1 : kept_count;

  always_comb begin
    phase_next        = phase;
    kept_count_next   = kept_count;
    frame_length_next = frame_length;
    res_emit          = 1'b0;
    res_pos           = kept_count;
    res_status        = spd_pkg::ST_KEPT;
    case (phase)
      PH_PRE0: begin
        if (in_byte == cfg.preamble_value) phase_next = PH_PRE1;
      end
      PH_PRE1: begin
        phase_next = (in_byte == cfg.preamble_value) ? PH_LEN : PH_PRE0;
      end
      PH_LEN: begin
        if (in_byte <= cfg.max_frame_length && in_byte >= cfg.min_frame_length) begin
          frame_length_next = in_byte;
          kept_count_next   = 8'd1;
          phase_next        = PH_ADDR;
          res_emit          = 1'b1;
          res_pos           = 8'd0;
        end else begin
          phase_next = PH_PRE0;
        end
      end
      PH_ADDR, PH_NETID: begin
        res_emit = 1'b1;
        if (in_byte == ((phase == PH_ADDR) ? cfg.own_address : cfg.network_id)) begin
          kept_count_next = kept_count + 8'd1;
          phase_next      = (phase == PH_ADDR) ? PH_NETID : PH_DATA;
        end else begin
          phase_next = PH_PRE0;
          res_status = spd_pkg::ST_ABANDONED;
        end
      end
      PH_DATA: begin
        res_emit        = 1'b1;
        kept_count_next = data_count;
        if (data_count >= frame_length) begin
          phase_next = PH_PRE0;
          res_status = data_kept ? spd_pkg::ST_LAST : spd_pkg::ST_DISCARDED;
        end
      end
      default: begin
        phase_next = PH_PRE0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PRE0;
      kept_count   <= 8'd0;
      frame_length <= 8'd0;
    end else if (advance) begin
      phase        <= phase_next;
      kept_count   <= kept_count_next;
      frame_length <= frame_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_emit) begin
      out_byte   <= in_byte;
      out_pos    <= res_pos;
      out_status <= res_status;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.frame_byte    = out_byte;
  assign tx.byte_position = out_pos;
  assign tx.status        = out_status;

endmodule

@@ rtl/serial_packet_deframer_core.sv @@
// An accepted byte that yields a result passes through the input register, then the
// result register; header and hunt bytes may yield none.
// Throughput: one byte per cycle while the result side takes results; the single-step parse state update sets it.
// Reset (synchronous, active high) returns to the preamble hunt, clears the
// byte count and length, empties both registers and restores register defaults.
`include "serial_packet_deframer_core_defines.svh"

module serial_packet_deframer_core (
  input  logic                      clk,
  input  logic                      rst,
  spd_rx_if.sink                    rx,
  spd_tx_if.source                  tx,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [spd_pkg::AddrW-1:0] paddr,
  input  logic [spd_pkg::DataW-1:0] pwdata,
  output logic [spd_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  spd_pkg::cfg_t cfg;

  spd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spd_parser u_parser (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .rx  (rx),
    .tx  (tx)
  );

  // With the result register empty, the input side never stalls.
  `SPD_ASSERT_IMPL(a_ready_when_empty, clk, rst, !tx.valid, rx.ready)
  // A frame can only be abandoned on its address or network id byte.
  `SPD_ASSERT_IMPL(a_abandon_pos, clk, rst, tx.valid && tx.status == spd_pkg::ST_ABANDONED, tx.byte_position == 8'd1 || tx.byte_position == 8'd2)
  // A discard only follows a complete three-byte header.
  `SPD_ASSERT_IMPL(a_discard_pos, clk, rst, tx.valid && tx.status == spd_pkg::ST_DISCARDED, tx.byte_position >= 8'd3)
  // The length byte always opens a frame as a kept item.
  `SPD_ASSERT_IMPL(a_len_kept, clk, rst, tx.valid && tx.byte_position == 8'd0, tx.status == spd_pkg::ST_KEPT)

endmodule

@@ tb/serial_packet_deframer_core_test.sv @@
`timescale 1ns / 1ps

typedef enum logic [2:0] {
  HUNT_PRE0,
  HUNT_PRE1,
  WANT_LEN,
  WANT_ADDR,
  WANT_NETID,
  IN_DATA
} parse_phase_t;

typedef struct packed {
  logic [7:0] frame_byte;
  logic [7:0] byte_position;
  logic [1:0] status;
} frame_result_t;

// Tracks the deframer's parse state and holds the frame bytes it should emit.
class frame_byte_tracker;
  spd_pkg::cfg_t   cfg;
  parse_phase_t    phase;
  logic [7:0]      kept_count;
  logic [7:0]      frame_length;
  frame_result_t   pending[$];
  int unsigned     failures;

  function new();
    cfg.preamble_value   = 8'd255;
    cfg.max_frame_length = 8'd128;
    cfg.min_frame_length = 8'd8;
    cfg.own_address      = 8'd1;
    cfg.network_id       = 8'd0;
    phase        = HUNT_PRE0;
    kept_count   = 8'd0;
    frame_length = 8'd0;
    failures     = 0;
  endfunction

  function void set_register(logic [2:0] idx, logic [7:0] value);
    case (idx)
      spd_pkg::REG_PREAMBLE: cfg.preamble_value   = value;
      spd_pkg::REG_MAX_LEN:  cfg.max_frame_length = value;
      spd_pkg::REG_MIN_LEN:  cfg.min_frame_length = value;
      spd_pkg::REG_OWN_ADDR: cfg.own_address      = value;
      spd_pkg::REG_NET_ID:   cfg.network_id       = value;
      default: ;
    endcase
  endfunction

  function void queue_result(logic [7:0] b, logic [7:0] pos, logic [1:0] st);
    frame_result_t r;
    r.frame_byte    = b;
    r.byte_position = pos;
    r.status        = st;
    pending.push_back(r);
  endfunction

  function void absorb_rx_byte(logic [7:0] c);
    logic [7:0] pos;
    logic [7:0] want;
    bit         kept;
    pos = kept_count;
    case (phase)
      HUNT_PRE0: begin
        if (c == cfg.preamble_value) phase = HUNT_PRE1;
      end
      HUNT_PRE1: begin
        phase = (c == cfg.preamble_value) ? WANT_LEN : HUNT_PRE0;
      end
      WANT_LEN: begin
        if (c <= cfg.max_frame_length && c >= cfg.min_frame_length) begin
          frame_length = c;
          kept_count   = 8'd1;
          phase        = WANT_ADDR;
          queue_result(c, 8'd0, spd_pkg::ST_KEPT);
        end else begin
          phase = HUNT_PRE0;
        end
      end
      WANT_ADDR, WANT_NETID: begin
        want = (phase == WANT_ADDR) ? cfg.own_address : cfg.network_id;
        if (c == want) begin
          kept_count = kept_count + 8'd1;
          phase      = (phase == WANT_ADDR) ? WANT_NETID : IN_DATA;
          queue_result(c, pos, spd_pkg::ST_KEPT);
        end else begin
          phase = HUNT_PRE0;
          queue_result(c, pos, spd_pkg::ST_ABANDONED);
        end
      end
      IN_DATA: begin
        kept = 1'b0;
        if (kept_count < frame_length) begin
          kept_count = kept_count + 8'd1;
          kept       = 1'b1;
        end
        if (kept_count >= frame_length) begin
          phase = HUNT_PRE0;
          queue_result(c, pos, kept ? spd_pkg::ST_LAST : spd_pkg::ST_DISCARDED);
        end else begin
          queue_result(c, pos, spd_pkg::ST_KEPT);
        end
      end
      default: phase = HUNT_PRE0;
    endcase
  endfunction

  function void match_frame_byte(logic [7:0] b, logic [7:0] pos, logic [1:0] st);
    frame_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result byte=%02h position=%0d status=%0d",
               $time, b, pos, st);
      failures++;
    end else begin
      want = pending.pop_front();
      if (want !== {b, pos, st}) begin
        $display("%0t: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                 $time, want.frame_byte, want.byte_position, want.status, b, pos, st);
        failures++;
      end
    end
  endfunction
endclass

module serial_packet_deframer_core_test;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned RANDOM_ITEMS  = 500;
  // Indexes with no register behind them; writes there must be ignored.
  localparam logic [2:0]  REG_UNUSED_LO = 3'd5;
  localparam logic [2:0]  REG_UNUSED_HI = 3'd7;

  // Ways a generated frame can be damaged.
  localparam int FLAW_NONE     = 0;
  localparam int FLAW_PREAMBLE = 1;
  localparam int FLAW_LENGTH   = 2;
  localparam int FLAW_ADDRESS  = 3;
  localparam int FLAW_NETID    = 4;
  localparam int FLAW_TRUNCATE = 5;
  localparam int FLAW_TRAILING = 6;
  localparam int FLAW_NOISE    = 7;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [spd_pkg::AddrW-1:0]  paddr;
  logic [spd_pkg::DataW-1:0]  pwdata;
  logic [spd_pkg::DataW-1:0]  prdata;
  logic                       pready;

  spd_rx_if rx_ch();
  spd_tx_if tx_ch();

  serial_packet_deframer_core dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .tx      (tx_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_byte_tracker tracker;
  int unsigned       cycle_count;
  int unsigned       bytes_sent;
  logic              no_gaps;
  logic              hold_trigger;
  int unsigned       hold_left;
  bit                hold_served;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) tracker.absorb_rx_byte(rx_ch.rx_byte);
      if (tx_ch.valid && tx_ch.ready) begin
        tracker.match_frame_byte(tx_ch.frame_byte, tx_ch.byte_position, tx_ch.status);
      end
    end
  end

  // Result side: random stalls, one long hold-off on request, none while no_gaps is set.
  always @(posedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b1;
    end else if (hold_left > 0) begin
      tx_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_trigger && !hold_served) begin
      hold_served = 1'b1;
      hold_left   = HOLD_CYCLES - 1;
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= no_gaps || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 6) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Lets every result come out and the input path empty before a register write.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
    logic [spd_pkg::DataW-1:0] word;
    word      = $urandom();
    word[7:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] pre, input logic [7:0] max_len,
                                input logic [7:0] min_len, input logic [7:0] addr,
                                input logic [7:0] net);
    settle();
    write_register(spd_pkg::REG_PREAMBLE, pre);
    write_register(spd_pkg::REG_MAX_LEN, max_len);
    write_register(spd_pkg::REG_MIN_LEN, min_len);
    write_register(spd_pkg::REG_OWN_ADDR, addr);
    write_register(spd_pkg::REG_NET_ID, net);
  endtask

  function automatic logic [7:0] flip_bit(logic [7:0] v);
    return v ^ (8'd1 << $urandom_range(7));
  endfunction

  task automatic send_frame(input logic [7:0] len, input int flaw);
    logic [7:0] seq[$];
    logic [7:0] pre;
    logic [7:0] lo;
    logic [7:0] hi;
    int         n;
    int         keep;
    pre = tracker.cfg.preamble_value;
    lo  = tracker.cfg.min_frame_length;
    hi  = tracker.cfg.max_frame_length;
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 6)) begin
        seq.push_back(($urandom_range(3) == 0) ? pre : 8'($urandom()));
      end
    end
    if (flaw == FLAW_LENGTH) begin
      if (hi < 8'd255 && $urandom_range(1)) len = 8'($urandom_range(hi + 1, 255));
      else len = 8'($urandom_range(0, lo - 1));
    end
    seq.push_back(pre);
    seq.push_back((flaw == FLAW_PREAMBLE) ? flip_bit(pre) : pre);
    seq.push_back(len);
    seq.push_back((flaw == FLAW_ADDRESS) ? flip_bit(tracker.cfg.own_address)
                                         : tracker.cfg.own_address);
    seq.push_back((flaw == FLAW_NETID) ? flip_bit(tracker.cfg.network_id)
                                       : tracker.cfg.network_id);
    n = (len > 3) ? len - 3 : 1;
    keep = (flaw == FLAW_TRUNCATE) ? $urandom_range(0, n - 1) : n;
    repeat (keep) seq.push_back(8'($urandom()));
    if (flaw == FLAW_TRAILING) begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom()));
    end
    send_seq(seq);
  endtask

  function automatic int pick_flaw();
    int r;
    r = $urandom_range(99);
    if (r < 70) return FLAW_NONE;
    return $urandom_range(FLAW_PREAMBLE, FLAW_NOISE);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned random_start;
    int unsigned phase_no;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  len;
    int          span;

    tracker       = new();
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    no_gaps       = 1'b0;
    hold_trigger  = 1'b0;
    bytes_sent    = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: broken preamble, lengths just outside the limits,
    // address and network id refusals, then a frame of the minimum length.
    send_seq('{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h07, 8'hFF, 8'hFF, 8'h81});
    send_seq('{8'hFF, 8'hFF, 8'h08, 8'h02});
    send_seq('{8'hFF, 8'hFF, 8'h08, 8'h01, 8'h05});
    send_seq('{8'hFF, 8'hFF, 8'h08, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80});

    // Widest limits. Lengths of one and three end in a discarded byte,
    // a length of four makes the first data byte the last.
    apply_settings(8'h00, 8'd255, 8'd1, 8'hFF, 8'hFF);
    write_register(REG_UNUSED_LO, 8'h12);
    write_register(REG_UNUSED_HI, 8'h34);
    send_frame(8'd1, FLAW_NONE);
    send_frame(8'd3, FLAW_NONE);
    send_frame(8'd4, FLAW_NONE);

    // Crossed limits: no length gets through, not even one between them.
    apply_settings(8'hFF, 8'd10, 8'd20, 8'h00, 8'h00);
    repeat (4) send_frame(8'($urandom_range(1, 30)), FLAW_NONE);

    random_start = bytes_sent;
    phase_no     = 0;
    while (phase_no < 4 || bytes_sent < random_start + RANDOM_ITEMS) begin
      lo = 8'($urandom_range(1, 10));
      hi = (phase_no == 3 || $urandom_range(7) == 0) ? 8'd255
                                                     : lo + 8'($urandom_range(0, 30));
      apply_settings(pick_byte(), hi, lo, pick_byte(), pick_byte());
      if (phase_no == 0) hold_trigger <= 1'b1;
      if (phase_no == 1) no_gaps <= 1'b1;
      if (phase_no == 2) no_gaps <= 1'b0;
      if (phase_no == 3) send_frame(8'd255, FLAW_NONE);
      repeat (5) begin
        span = hi - lo;
        if (span > 20) span = 20;
        len = lo + 8'($urandom_range(0, span));
        send_frame(len, pick_flaw());
      end
      phase_no++;
    end

    settle();
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ serial_packet_deframer_core.f @@
+incdir+rtl
rtl/spd_pkg.sv
rtl/spd_if.sv
rtl/spd_cfg_regs.sv
rtl/spd_parser.sv
rtl/serial_packet_deframer_core.sv
tb/serial_packet_deframer_core_test.sv
